### hw/rtl/mrf_pkg.sv
// Shared constants, types and helpers for the microdrive record framer.
`timescale 1ns / 1ps

package mrf_pkg;

    localparam int PAYLOAD_BYTES = 512;
    localparam int POS_W         = $clog2(PAYLOAD_BYTES);
    localparam int NAME_LEN      = 10;
    localparam int NAME_W        = 8 * NAME_LEN;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NAME_LOW    = 2'd0;
    localparam logic [1:0] CFG_NAME_HIGH   = 2'd1;
    localparam logic [1:0] CFG_LAST_RECORD = 2'd2;

    // Register reset values.
    localparam logic [63:0] NAME_LOW_RST    = 64'h2020_2020_2020_2020;
    localparam logic [15:0] NAME_HIGH_RST   = 16'h2020;
    localparam logic [7:0]  LAST_RECORD_RST = 8'd253;

    // Emit phase of the held item: two 15-byte headers, data byte, data checksum.
    typedef logic [4:0] t_phase;
    localparam t_phase PH_SECTOR  = 5'd0;
    localparam t_phase PH_BLOCK   = 5'd15;
    localparam t_phase PH_DATA    = 5'd30;
    localparam t_phase PH_DATA_CK = 5'd31;

    // Byte slots within one header.
    typedef logic [3:0] t_hslot;
    localparam t_hslot HS_FLAG  = 4'd0;
    localparam t_hslot HS_REC   = 4'd1;
    localparam t_hslot HS_ZERO  = 4'd2;
    localparam t_hslot HS_TYPE  = 4'd3;
    localparam t_hslot HS_NAME0 = 4'd4;
    localparam t_hslot HS_CK    = 4'd14;

    localparam logic [7:0] SECTOR_FLAG = 8'd1;
    localparam logic [7:0] BLOCK_FLAG  = 8'd0;
    localparam logic [7:0] SECTOR_TYPE = 8'd0;
    localparam logic [7:0] BLOCK_TYPE  = 8'd2;

    localparam logic [8:0] MOD_SUM = 9'd255;

    // (a + b) mod 255 with a already reduced (0..254).
    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MOD_SUM) begin
            s = s - MOD_SUM;
        end
        return s[7:0];
    endfunction

endpackage

### hw/rtl/microdrive_record_framer_core.sv
// Microdrive record framer: payload bytes in, framed sector/block records out.
`timescale 1ns / 1ps

// Takes payload bytes and frames every run of 512 as one microdrive record.
// The first byte of a record is preceded by a 15-byte sector header (flag 1,
// record number, 0, 0, ten name bytes, checksum) and a 15-byte block header
// (flag 0, record number, 0, 2, name, checksum); the 512th byte is followed
// by the data checksum, flagged by record_end. Checksums are byte sums mod 255.
// run_last marks the final output byte caused by each input transfer.
// Output runs at one byte per cycle while i_out_stall is low. An input byte
// occupies a single holding register until all of its output bytes have
// moved to the output register: one for an ordinary byte, two for the last
// byte of a record and 31 for the first, and input is stalled for the rest of
// that burst. A new byte is taken in the same cycle the previous one's last
// result is loaded, so plain payload flows back to back. Record number wraps
// from last_record to 1. Configuration is to be written only while the block
// is idle; the block itself does not enforce this. Index 3 is ignored.

module microdrive_record_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    // payload input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_payload_byte,
    // framed output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_record_end,
    output logic        o_run_last
);

    // configuration registers
    logic [63:0] r_name_low;
    logic [15:0] r_name_high;
    logic [7:0]  r_last_record;

    // record state, advanced when a payload byte is transferred in
    logic [mrf_pkg::POS_W-1:0] r_pos;
    logic [7:0]                r_rec;
    logic [7:0]                r_dsum;

    // holding register for the byte being framed
    logic                r_hold_valid;
    logic [7:0]          r_hold_byte;
    logic                r_hold_last;
    logic [7:0]          r_hold_ck;
    mrf_pkg::t_phase     r_phase;
    logic [7:0]          r_hsum;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic       r_out_last;

    logic                        w_in_xfer;
    logic                        w_out_load;
    logic                        w_done;
    logic                        w_first;
    logic                        w_last;
    logic [7:0]                  w_dsum;
    logic                        w_in_hdr;
    logic                        w_sector;
    mrf_pkg::t_hslot             w_hslot;
    mrf_pkg::t_hslot             w_nidx;
    logic [mrf_pkg::NAME_W-1:0]  w_name;
    logic [7:0]                  w_name_byte;
    logic [7:0]                  w_hdr_byte;
    logic [7:0]                  w_byte;
    logic                        w_end;
    logic                        w_run_last;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign w_out_load = r_hold_valid && (!r_out_valid || !i_out_stall);
    assign w_done     = w_out_load && w_run_last;
    assign o_in_stall = r_hold_valid && !w_done;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------
    // Record position and data checksum, evaluated on input transfer
    // ---------------------------------------------------------------
    assign w_first = (r_pos == '0);
    assign w_last  = (r_pos == mrf_pkg::POS_W'(mrf_pkg::PAYLOAD_BYTES - 1));
    assign w_dsum  = mrf_pkg::add_mod255(w_first ? 8'd0 : r_dsum, i_payload_byte);

    // ---------------------------------------------------------------
    // Header byte generation; checksum accumulates as bytes go out
    // ---------------------------------------------------------------
    assign w_in_hdr = (r_phase < mrf_pkg::PH_DATA);
    assign w_sector = (r_phase < mrf_pkg::PH_BLOCK);
    assign w_hslot  = w_sector ? r_phase[3:0] : 4'(r_phase - mrf_pkg::PH_BLOCK);
    assign w_nidx   = w_hslot - mrf_pkg::HS_NAME0;
    assign w_name   = {r_name_high, r_name_low};

    always_comb begin
        w_name_byte = '0;
        for (int i = 0; i < mrf_pkg::NAME_LEN; i++) begin
            if (w_nidx == 4'(i)) begin
                w_name_byte = w_name[i*8 +: 8];
            end
        end
    end

    always_comb begin
        case (w_hslot)
            mrf_pkg::HS_FLAG: w_hdr_byte = w_sector ? mrf_pkg::SECTOR_FLAG
                                                    : mrf_pkg::BLOCK_FLAG;
            mrf_pkg::HS_REC:  w_hdr_byte = r_rec;
            mrf_pkg::HS_ZERO: w_hdr_byte = 8'd0;
            mrf_pkg::HS_TYPE: w_hdr_byte = w_sector ? mrf_pkg::SECTOR_TYPE
                                                    : mrf_pkg::BLOCK_TYPE;
            mrf_pkg::HS_CK:   w_hdr_byte = r_hsum;
            default:          w_hdr_byte = w_name_byte;
        endcase
    end

    always_comb begin
        w_end      = 1'b0;
        w_run_last = 1'b0;
        if (w_in_hdr) begin
            w_byte = w_hdr_byte;
        end else if (r_phase == mrf_pkg::PH_DATA) begin
            w_byte     = r_hold_byte;
            w_run_last = !r_hold_last;
        end else begin
            w_byte     = r_hold_ck;
            w_end      = 1'b1;
            w_run_last = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_low    <= mrf_pkg::NAME_LOW_RST;
            r_name_high   <= mrf_pkg::NAME_HIGH_RST;
            r_last_record <= mrf_pkg::LAST_RECORD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mrf_pkg::CFG_NAME_LOW:    r_name_low    <= i_cfg_data;
                mrf_pkg::CFG_NAME_HIGH:   r_name_high   <= i_cfg_data[15:0];
                mrf_pkg::CFG_LAST_RECORD: r_last_record <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_rec        <= 8'd1;
            r_dsum       <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_hold_valid <= 1'b1;
                r_pos        <= w_last ? '0 : r_pos + 1'b1;
                r_dsum       <= w_last ? 8'd0 : w_dsum;
                if (w_last) begin
                    r_rec <= (r_rec >= r_last_record) ? 8'd1 : r_rec + 8'd1;
                end
            end else if (w_done) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    // payload side of the holding register
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_hold_byte <= i_payload_byte;
            r_hold_last <= w_last;
            r_hold_ck   <= w_dsum;
            r_phase     <= w_first ? mrf_pkg::PH_SECTOR : mrf_pkg::PH_DATA;
        end else if (w_out_load) begin
            r_phase <= r_phase + 5'd1;
        end
        if (w_out_load && w_in_hdr && (w_hslot != mrf_pkg::HS_CK)) begin
            r_hsum <= mrf_pkg::add_mod255(
                (w_hslot == mrf_pkg::HS_FLAG) ? 8'd0 : r_hsum, w_hdr_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_byte <= w_byte;
            r_out_end  <= w_end;
            r_out_last <= w_run_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_record_end = r_out_end;
    assign o_run_last   = r_out_last;

endmodule

### bench/microdrive_record_framer_checker.sv
// Checker for the microdrive record framer: predicts the framed stream and compares it.
`timescale 1ns / 1ps

module microdrive_record_framer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_record_end,
    input  logic        i_run_last,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [63:0] NAME_LO_INIT  = 64'h2020_2020_2020_2020;
    localparam logic [15:0] NAME_HI_INIT  = 16'h2020;
    localparam logic [7:0]  LAST_REC_INIT = 8'd253;
    localparam int          RECORD_LEN    = 512;
    localparam int          SUM_MOD       = 255;

    localparam logic [7:0] FLAG_SECTOR = 8'd1;
    localparam logic [7:0] FLAG_BLOCK  = 8'd0;
    localparam logic [7:0] KIND_SECTOR = 8'd0;
    localparam logic [7:0] KIND_BLOCK  = 8'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       rec_end;
        logic       run_last;
    } t_framed_byte;

    t_framed_byte expected_frame_bytes[$];

    // Shadow of the register file and of the framing state.
    logic [63:0] name_lo;
    logic [15:0] name_hi;
    logic [7:0]  last_rec;
    logic [7:0]  rec_num;
    int          payload_pos;
    int          data_sum;
    int          fails = 0;

    function automatic logic [7:0] name_at(input int idx);
        if (idx < 8) begin
            return name_lo[8*idx +: 8];
        end
        return name_hi[8*(idx-8) +: 8];
    endfunction

    task automatic queue_header(input logic [7:0] flag, input logic [7:0] kind);
        logic [7:0] hdr [0:13];
        logic [7:0] ck;
        int         sum;
        hdr[0] = flag;
        hdr[1] = rec_num;
        hdr[2] = 8'd0;
        hdr[3] = kind;
        for (int i = 0; i < 10; i++) begin
            hdr[4+i] = name_at(i);
        end
        sum = 0;
        for (int i = 0; i < 14; i++) begin
            sum += hdr[i];
            expected_frame_bytes.push_back('{data: hdr[i], rec_end: 1'b0, run_last: 1'b0});
        end
        ck = 8'(sum % SUM_MOD);
        expected_frame_bytes.push_back('{data: ck, rec_end: 1'b0, run_last: 1'b0});
    endtask

    task automatic frame_payload_byte(input logic [7:0] b);
        logic [7:0] ck;
        if (payload_pos == 0) begin
            queue_header(FLAG_SECTOR, KIND_SECTOR);
            queue_header(FLAG_BLOCK, KIND_BLOCK);
            data_sum = 0;
        end
        data_sum    = (data_sum + b) % SUM_MOD;
        payload_pos = payload_pos + 1;
        if (payload_pos >= RECORD_LEN) begin
            ck = 8'(data_sum);
            expected_frame_bytes.push_back('{data: b, rec_end: 1'b0, run_last: 1'b0});
            expected_frame_bytes.push_back('{data: ck, rec_end: 1'b1, run_last: 1'b1});
            payload_pos = 0;
            data_sum    = 0;
            // wrap also covers last_record of zero or below the current number
            if (rec_num >= last_rec) begin
                rec_num = 8'd1;
            end else begin
                rec_num = rec_num + 8'd1;
            end
        end else begin
            expected_frame_bytes.push_back('{data: b, rec_end: 1'b0, run_last: 1'b1});
        end
    endtask

    task automatic check_frame_byte();
        t_framed_byte exp_fb;
        if (expected_frame_bytes.size() == 0) begin
            $error("unexpected output transfer: out_byte %0h", i_out_byte);
            fails++;
            return;
        end
        exp_fb = expected_frame_bytes.pop_front();
        if (i_out_byte !== exp_fb.data) begin
            $error("out_byte mismatch: expected %0h actual %0h", exp_fb.data, i_out_byte);
            fails++;
        end
        if (i_record_end !== exp_fb.rec_end) begin
            $error("record_end mismatch: expected %0b actual %0b",
                   exp_fb.rec_end, i_record_end);
            fails++;
        end
        if (i_run_last !== exp_fb.run_last) begin
            $error("run_last mismatch: expected %0b actual %0b",
                   exp_fb.run_last, i_run_last);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            name_lo     = NAME_LO_INIT;
            name_hi     = NAME_HI_INIT;
            last_rec    = LAST_REC_INIT;
            rec_num     = 8'd1;
            payload_pos = 0;
            data_sum    = 0;
            expected_frame_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mrf_pkg::CFG_NAME_LOW: begin
                        name_lo = i_cfg_data;
                    end
                    mrf_pkg::CFG_NAME_HIGH: begin
                        name_hi = i_cfg_data[15:0];
                    end
                    mrf_pkg::CFG_LAST_RECORD: begin
                        last_rec = i_cfg_data[7:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                frame_payload_byte(i_payload_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                check_frame_byte();
            end
        end
        o_pending    <= expected_frame_bytes.size();
        o_fail_count <= fails;
    end

endmodule

### bench/microdrive_record_framer_core_tb.sv
// Testbench top for the microdrive record framer: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

// Drives payload bytes into the framer with random gaps while the output side
// stalls at random. One full record of 512 payload bytes is sent, with the
// registers rewritten halfway, and then a few bytes of the next record so its
// headers come out. The checker beside the DUT predicts the framed stream
// and counts mismatches; this module only makes traffic and calls the verdict.

module microdrive_record_framer_core_tb;

    localparam int          CLK_PERIOD     = 20;
    localparam int          RECORD_LEN     = 512;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 40;
    // Index past the register list; the block must ignore writes to it.
    localparam logic [1:0]  CFG_UNUSED     = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_payload_byte;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_record_end;
    logic        o_run_last;

    int fail_count;
    int pending;
    int idle_cycles;

    // When set, the sender pushes back to back with no gaps.
    logic steady;

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    microdrive_record_framer_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_payload_byte (i_payload_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_record_end   (o_record_end),
        .o_run_last     (o_run_last)
    );

    microdrive_record_framer_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_payload_byte (i_payload_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_byte     (o_out_byte),
        .i_record_end   (o_record_end),
        .i_run_last     (o_run_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Receiver back-pressure: runs of open or stalled cycles, mostly short,
    // now and then a long stall or a long open stretch.
    int  stall_left = 0;
    logic stall_now = 1'b0;
    always @(negedge i_clk) begin
        int r;
        if (stall_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                stall_now  = 1'b0;
                stall_left = $urandom_range(1, 8);
            end else if (r < 60) begin
                stall_now  = 1'b0;
                stall_left = $urandom_range(30, 120);
            end else if (r < 92) begin
                stall_now  = 1'b1;
                stall_left = $urandom_range(1, 3);
            end else begin
                stall_now  = 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
        stall_left  = stall_left - 1;
        i_out_stall <= stall_now;
    end

    // Watchdog: a long stretch with no transfer on either side means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Random payload with extra weight on the extremes.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One input transfer. Valid stays high across back-to-back transfers;
    // it drops only for a gap, in a different time step from its rise.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_payload_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            push_byte(pick_byte());
        end
        steady = 1'b0;
    endtask

    // Sender goes quiet until the checker holds no more expected bytes.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    logic [7:0] directed_bytes [0:9] = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80,
                                         8'h7F, 8'hAA, 8'h55, 8'hFF, 8'hFF};

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = mrf_pkg::CFG_NAME_LOW;
        i_cfg_data     = 64'd0;
        i_in_valid     = 1'b0;
        i_payload_byte = 8'd0;
        steady         = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Record 1 under reset settings: field extremes first, so the
        // headers carry the default name and record number 1.
        foreach (directed_bytes[k]) begin
            push_byte(directed_bytes[k]);
        end
        drain();
        // Write past the register list mid-record; nothing may change.
        cfg_write(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_random(250);

        // New name and last_record 2 halfway through the record: headers
        // already out keep the old name, the next record takes number 2.
        drain();
        cfg_write(mrf_pkg::CFG_NAME_LOW, rand64());
        cfg_write(mrf_pkg::CFG_NAME_HIGH, rand64());
        cfg_write(mrf_pkg::CFG_LAST_RECORD, 64'd2);
        send_random(RECORD_LEN - 260);

        // A few bytes into record 2 bring out its headers.
        send_random(4);

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### microdrive_record_framer_core.f
hw/rtl/mrf_pkg.sv
hw/rtl/microdrive_record_framer_core.sv
bench/microdrive_record_framer_checker.sv
bench/microdrive_record_framer_core_tb.sv
